[rtl/core/netstring_stream_deframer_defines.svh]
// assertion macros for the checker file
`ifndef NETSTRING_STREAM_DEFRAMER_DEFINES_SVH
`define NETSTRING_STREAM_DEFRAMER_DEFINES_SVH

// same-cycle implication, off while reset is low
`define NSD_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define NSD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also runs through reset
`define NSD_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/nsd_pkg.sv]
package nsd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 17;
    localparam int MAX_LEN_W           = 17;   // register and output length width
    localparam int BYTE_W              = 8;
    localparam int KIND_W              = 2;
    localparam int CMP_W               = 36;   // holds length*10+9 for length widths up to 32
    localparam int TDATA_W             = 32;   // data_byte + frame_length, byte padded

    localparam logic [MAX_LEN_W-1:0] HARD_LIMIT = 17'd100000;

    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_COMMA   = 2'd2
    } phase_t;

    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    data_byte;
        logic [MAX_LEN_W-1:0] frame_length;
    } result_t;

endpackage

[rtl/core/netstring_stream_deframer.sv]
// channel  | dir | tdata (low bit up)                     | tuser
// ---------+-----+----------------------------------------+------------
// s_       | in  | [7:0] in_byte                          | -
// m_       | out | [7:0] data_byte, [24:8] frame_length   | [1:0] kind
// cfg_     | in  | cfg_wdata[16:0] max_length, on cfg_we  | -
//
// one byte per cycle while m_ drains: each input transaction is decoded in a single pass from the
// phase/length registers into the output register, so s_tready stays high unless m_tready stalls it
// timing: the output is registered; a result appears on m_ in the cycle after the byte that causes it
// reset: aresetn low at a clock edge returns to the length phase, empties the
// output register and reloads max_length with 100000
// stalls: input is taken while the output register is empty or being drained;
// a held m_ transaction stays stable until m_tready
module netstring_stream_deframer import nsd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write, no read-back
    input  logic                 cfg_we,
    input  logic [MAX_LEN_W-1:0] cfg_wdata,   // [16:0] max_length
    // byte stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,     // [7:0] in_byte
    // decoded stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,     // [7:0] data_byte, [24:8] frame_length
    output logic [KIND_W-1:0]    m_tuser      // [1:0] kind
);

    // deframer state
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [LENGTH_BITS-1:0] accum_reg;
    logic [LENGTH_BITS-1:0] accum_next;
    logic [LENGTH_BITS-1:0] left_reg;
    logic [LENGTH_BITS-1:0] left_next;
    logic [MAX_LEN_W-1:0]   max_length_reg;

    result_t result;
    logic    room;
    logic    accept;

    // a byte is taken whenever the output register can hold whatever it yields
    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    // single-pass decode of one byte against current state
    nsd_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .phase      (phase_reg),
        .accum      (accum_reg),
        .left       (left_reg),
        .max_length (max_length_reg),
        .in_byte    (s_tdata),
        .phase_next (phase_next),
        .accum_next (accum_next),
        .left_next  (left_next),
        .result     (result)
    );

    // state only advances on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LENGTH;
            accum_reg <= '0;
            left_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
        end
    end

    // length limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= HARD_LIMIT;
        end else if (cfg_we) begin
            max_length_reg <= cfg_wdata;
        end
    end

    // output register; bytes with no result (digits, colon) load nothing
    nsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && result.valid),
        .result   (result),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/nsd_step.sv]
module nsd_step import nsd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  phase_t                 phase,
    input  logic [LENGTH_BITS-1:0] accum,
    input  logic [LENGTH_BITS-1:0] left,
    input  logic [MAX_LEN_W-1:0]   max_length,
    input  logic [BYTE_W-1:0]      in_byte,
    output phase_t                 phase_next,
    output logic [LENGTH_BITS-1:0] accum_next,
    output logic [LENGTH_BITS-1:0] left_next,
    output result_t                result
);

    localparam logic [CMP_W-1:0] LEN_MASK = (CMP_W'(1) << LENGTH_BITS) - CMP_W'(1);

    logic [CMP_W-1:0]       accum_ext;
    logic [CMP_W-1:0]       times_ten;
    logic [CMP_W-1:0]       grown;
    logic [BYTE_W-1:0]      digit;
    logic                   is_digit;
    logic                   too_long;
    logic [LENGTH_BITS-1:0] left_dec;

    assign accum_ext = CMP_W'(accum);
    assign times_ten = (accum_ext << 3) + (accum_ext << 1);
    assign digit     = in_byte - CHAR_ZERO;
    assign grown     = times_ten + CMP_W'(digit);
    assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign too_long  = (grown > CMP_W'(HARD_LIMIT)) || (grown > CMP_W'(max_length))
                       || (grown > LEN_MASK);
    assign left_dec  = left - LENGTH_BITS'(1);

    always_comb begin
        phase_next = phase;
        accum_next = accum;
        left_next  = left;
        result     = '0;
        unique case (phase)
            PH_PAYLOAD: begin
                left_next        = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_COMMA;
                end
                result.valid     = 1'b1;
                result.kind      = KIND_DATA;
                result.data_byte = in_byte;
            end
            PH_COMMA: begin
                phase_next   = PH_LENGTH;
                accum_next   = '0;
                left_next    = '0;
                result.valid = 1'b1;
                if (in_byte == CHAR_COMMA) begin
                    result.kind         = KIND_DONE;
                    result.frame_length = MAX_LEN_W'(accum);
                end else begin
                    result.kind = KIND_ERROR;
                end
            end
            default: begin
                // length digits; the unused phase code behaves the same
                if (in_byte == CHAR_COLON) begin
                    left_next  = accum;
                    phase_next = (accum == '0) ? PH_COMMA : PH_PAYLOAD;
                end else if (!is_digit || too_long) begin
                    phase_next   = PH_LENGTH;
                    accum_next   = '0;
                    left_next    = '0;
                    result.valid = 1'b1;
                    result.kind  = KIND_ERROR;
                end else begin
                    accum_next = LENGTH_BITS'(grown);
                    phase_next = PH_LENGTH;
                end
            end
        endcase
    end

endmodule

[rtl/core/nsd_out_stage.sv]
module nsd_out_stage import nsd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  result_t               result,
    output logic                  room,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [KIND_W-1:0]     m_tuser
);

    localparam int PAD_W = TDATA_W - BYTE_W - MAX_LEN_W;

    logic                 valid_reg;
    logic                 valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [BYTE_W-1:0]    data_reg;
    logic [MAX_LEN_W-1:0] len_reg;

    // free when empty or when the held transaction leaves this cycle
    assign room = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= result.kind;
            data_reg <= result.data_byte;
            len_reg  <= result.frame_length;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, len_reg, data_reg};

endmodule

[rtl/core/nsd_checker.sv]
`include "netstring_stream_deframer_defines.svh"

module nsd_checker import nsd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TDATA_W-1:0]   m_tdata,
    input logic [KIND_W-1:0]    m_tuser
);

    `NSD_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "output changed while stalled")

    `NSD_ASSERT_NOW(a_len_only_done, aclk, aresetn,
        m_tvalid && (m_tuser != KIND_DONE),
        m_tdata[24:8] == '0,
        "frame length nonzero outside frame done")

    `NSD_ASSERT_NOW(a_data_only_payload, aclk, aresetn,
        m_tvalid && (m_tuser != KIND_DATA),
        (m_tdata[7:0] == '0) && (m_tdata[31:25] == '0),
        "data byte nonzero outside payload")

    `NSD_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk,
        !aresetn,
        !m_tvalid && s_tready,
        "output not empty after reset")

endmodule

bind netstring_stream_deframer nsd_checker u_nsd_checker (.*);

[sim/netstring_stream_deframer_tb.sv]
module netstring_stream_deframer_tb import nsd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_BITS = LENGTH_BITS_DEFAULT;
    localparam logic [CMP_W-1:0] LEN_MASK = (CMP_W'(1) << LEN_BITS) - CMP_W'(1);
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned ITEMS_PER_SETTING = 315;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    data_byte;
        logic [MAX_LEN_W-1:0] frame_length;
    } deframe_out_t;

    // tracks the netstring decode and holds the outputs still due from the block
    class netstring_decode_check;
        phase_t               phase;
        logic [LEN_BITS-1:0]  length_sum;
        logic [LEN_BITS-1:0]  payload_left;
        logic [MAX_LEN_W-1:0] max_length;
        deframe_out_t         due_outputs[$];
        int unsigned          fail_count;

        function new();
            max_length = HARD_LIMIT;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            phase        = PH_LENGTH;
            length_sum   = '0;
            payload_left = '0;
        endfunction

        function void push_out(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d,
                               logic [MAX_LEN_W-1:0] l);
            deframe_out_t o;
            o.kind         = k;
            o.data_byte    = d;
            o.frame_length = l;
            due_outputs.push_back(o);
        endfunction

        // one accepted stream byte
        function void accept_byte(logic [BYTE_W-1:0] b);
            logic [CMP_W-1:0]    next_len;
            logic [LEN_BITS-1:0] done_len;
            case (phase)
                PH_PAYLOAD: begin
                    payload_left = payload_left - 1'b1;
                    if (payload_left == '0) begin
                        phase = PH_COMMA;
                    end
                    push_out(KIND_DATA, b, '0);
                end
                PH_COMMA: begin
                    done_len = length_sum;
                    restart();
                    if (b == CHAR_COMMA) begin
                        push_out(KIND_DONE, '0, done_len[MAX_LEN_W-1:0]);
                    end else begin
                        push_out(KIND_ERROR, '0, '0);
                    end
                end
                default: begin
                    // length digits; an unused phase value acts the same
                    if (b == CHAR_COLON) begin
                        payload_left = length_sum;
                        if (length_sum == '0) begin
                            phase = PH_COMMA;
                        end else begin
                            phase = PH_PAYLOAD;
                        end
                    end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
                        restart();
                        push_out(KIND_ERROR, '0, '0);
                    end else begin
                        next_len = CMP_W'(length_sum) * CMP_W'(10) + CMP_W'(b - CHAR_ZERO);
                        if (next_len > CMP_W'(HARD_LIMIT) || next_len > CMP_W'(max_length)
                            || next_len > LEN_MASK) begin
                            restart();
                            push_out(KIND_ERROR, '0, '0);
                        end else begin
                            length_sum = next_len[LEN_BITS-1:0];
                            phase      = PH_LENGTH;
                        end
                    end
                end
            endcase
        endfunction

        // one accepted output transaction against the oldest one due
        function void check_output(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d,
                                   logic [MAX_LEN_W-1:0] l);
            deframe_out_t want;
            if (due_outputs.size() == 0) begin
                $error("unexpected output: kind %0d data_byte 0x%02h frame_length %0d",
                       k, d, l);
                fail_count++;
                return;
            end
            want = due_outputs.pop_front();
            if (want.kind !== k) begin
                $error("kind: expected %0d, actual %0d", want.kind, k);
                fail_count++;
            end
            if (want.data_byte !== d) begin
                $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, d);
                fail_count++;
            end
            if (want.frame_length !== l) begin
                $error("frame_length: expected %0d, actual %0d", want.frame_length, l);
                fail_count++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [MAX_LEN_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;    // [7:0] in_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;           // [7:0] data_byte, [24:8] frame_length
    logic [KIND_W-1:0]    m_tuser;           // [1:0] kind

    // idling controls for the sender (gaps) and the receiver (stalls, long hold)
    bit                   gaps_on       = 1'b1;
    bit                   stalls_on     = 1'b1;
    bit                   long_hold_req = 1'b0;
    int unsigned          bytes_sent    = 0;
    logic [MAX_LEN_W-1:0] max_len_now   = HARD_LIMIT;

    netstring_decode_check decode_chk = new();

    netstring_stream_deframer #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: check each accepted transaction, then pick the next tready
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                decode_chk.check_output(m_tuser, m_tdata[BYTE_W-1:0],
                                        m_tdata[BYTE_W +: MAX_LEN_W]);
            end
            if (long_hold_req) begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one byte, optionally after a gap, and wait for its transaction
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_chk.accept_byte(b);
        bytes_sent++;
    endtask

    // ascii decimal digits, most significant first
    task automatic send_decimal(input int unsigned v);
        logic [BYTE_W-1:0] digits[$];
        do begin
            digits.push_front(BYTE_W'(v % 10) + CHAR_ZERO);
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) send_byte(digits[i]);
    endtask

    task automatic send_netstring(input int unsigned len, input bit good_trailer);
        // zero length sometimes goes out as an empty length field
        if (len != 0 || $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 7) == 0) begin
                send_byte(CHAR_ZERO);
            end
            send_decimal(len);
        end
        send_byte(CHAR_COLON);
        repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
        if (good_trailer) begin
            send_byte(CHAR_COMMA);
        end else begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // mostly well-formed frames, some noise and broken framing
    task automatic send_random_item();
        int unsigned       pick;
        int unsigned       len;
        logic [BYTE_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end else if (pick < 14) begin
            // length cut off by a stray non-digit
            send_decimal($urandom_range(0, 60));
            do b = BYTE_W'($urandom_range(0, 255));
            while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_COLON);
            send_byte(b);
        end else if (pick < 18) begin
            // length over the limit
            send_decimal(int'(max_len_now) + $urandom_range(1, 2000));
        end else begin
            len = $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(9, 40);
            end
            if (len > max_len_now) begin
                len = $urandom_range(0, int'(max_len_now));
            end
            send_netstring(len, $urandom_range(0, 9) != 0);
        end
    endtask

    // sender pause until every due output has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (decode_chk.due_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [MAX_LEN_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        decode_chk.max_length = v;
        max_len_now           = v;
    endtask

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("netstring_stream_deframer: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [MAX_LEN_W-1:0] settings [6];
        int unsigned          budget;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero length, then an empty length field
        send_byte(CHAR_ZERO);
        send_byte(CHAR_COLON);
        send_byte(CHAR_COMMA);
        send_byte(CHAR_COLON);
        send_byte(CHAR_COMMA);
        // payload with byte extremes and an embedded comma
        send_decimal(3);
        send_byte(CHAR_COLON);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_COMMA);
        send_byte(CHAR_COMMA);
        // non-digits in the length field
        send_byte(8'hFF);
        send_byte(8'h00);
        // bad trailer after the payload
        send_decimal(1);
        send_byte(CHAR_COLON);
        send_byte(8'h61);
        send_byte(8'h78);
        // length one above the fixed ceiling, flagged on the last digit
        send_decimal(100001);

        settings[0] = HARD_LIMIT;
        settings[1] = '0;
        settings[2] = {MAX_LEN_W{1'b1}};
        settings[3] = MAX_LEN_W'(7);
        settings[4] = MAX_LEN_W'($urandom_range(0, 100000));
        settings[5] = HARD_LIMIT;

        for (int p = 0; p < 6; p++) begin
            write_max_length(settings[p]);
            if (p == 0) begin
                // receiver holds off while the sender keeps offering bytes
                long_hold_req = 1'b1;
                gaps_on       = 1'b0;
                send_netstring(60, 1'b1);
                gaps_on = 1'b1;
                wait_drained();
            end
            if (p == 5) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            budget = bytes_sent + ITEMS_PER_SETTING;
            while (bytes_sent < budget) send_random_item();
        end

        s_tvalid <= 1'b0;
        while (decode_chk.due_outputs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (decode_chk.fail_count == 0 && decode_chk.due_outputs.size() == 0) begin
            $display("netstring_stream_deframer: match");
        end else begin
            $display("netstring_stream_deframer: mismatch");
        end
        $finish;
    end

endmodule
